/* design/rdq_pkg.sv */
// shared constants, codes and types of the ring deque
`default_nettype none
package rdq_pkg;

  localparam int DEPTH    = 16;
  localparam int COUNT_W  = $clog2(DEPTH + 1);
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE     = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic [2:0] CMD_HOLD       = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [2:0] CMD_POP        = 3'd3;
  localparam logic [2:0] CMD_REMOVE     = 3'd4;

  typedef struct packed {
    logic [2:0]         code;
    logic               capture;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] front_value;
    logic               found;
  } chain_stat_t;

endpackage
`default_nettype wire

/* design/rdq_req_if.sv */
// request channel: operation and value
`default_nettype none
interface rdq_req_if;
  logic                         valid;
  logic                         ready;
  logic [rdq_pkg::OP_W-1:0]     operation;
  logic [rdq_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, operation, item_value, input ready);
  modport sink (input valid, operation, item_value, output ready);
endinterface
`default_nettype wire

/* design/rdq_rsp_if.sv */
// response channel: popped value, status and fill state
`default_nettype none
interface rdq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rdq_pkg::VALUE_W-1:0]   popped_value;
  logic [rdq_pkg::STATUS_W-1:0]  status;
  logic [rdq_pkg::COUNT_W-1:0]   entry_count;
  logic                          is_empty;

  modport source (output valid, popped_value, status, entry_count, is_empty, input ready);
  modport sink (input valid, popped_value, status, entry_count, is_empty, output ready);
endinterface
`default_nettype wire

/* design/rdq_cell.sv */
// one deque position: entry, occupied flag and match flag
`default_nettype none
module rdq_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rdq_pkg::cell_cmd_t           cmd,
  input  wire logic [rdq_pkg::VALUE_W-1:0]  left_data,
  input  wire logic                         left_valid,
  input  wire logic                         left_seen,
  input  wire logic [rdq_pkg::VALUE_W-1:0]  right_data,
  input  wire logic                         right_valid,
  output logic      [rdq_pkg::VALUE_W-1:0]  data,
  output logic                              valid,
  output logic                              seen
);

  logic match;

  assign seen = left_seen | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (cmd.capture) begin
        match <= valid && (data == cmd.value);
      end
      case (cmd.code)
        rdq_pkg::CMD_PUSH_BACK: begin
          if (!valid && left_valid) valid <= 1'b1;
        end
        rdq_pkg::CMD_PUSH_FRONT: valid <= left_valid;
        rdq_pkg::CMD_POP:        valid <= right_valid;
        rdq_pkg::CMD_REMOVE: begin
          if (seen) valid <= right_valid;
        end
        default: valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.code)
      rdq_pkg::CMD_PUSH_BACK: begin
        if (!valid && left_valid) data <= cmd.value;
      end
      rdq_pkg::CMD_PUSH_FRONT: data <= left_data;
      rdq_pkg::CMD_POP:        data <= right_data;
      rdq_pkg::CMD_REMOVE: begin
        if (seen) data <= right_data;
      end
      default: data <= data;
    endcase
  end

endmodule
`default_nettype wire

/* design/rdq_chain.sv */
// row of deque cells, front at position zero
`default_nettype none
module rdq_chain (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rdq_pkg::cell_cmd_t  cmd,
  output rdq_pkg::chain_stat_t     stat
);

  logic [rdq_pkg::VALUE_W-1:0] data  [rdq_pkg::DEPTH];
  logic                        valid [rdq_pkg::DEPTH];
  logic                        seen  [rdq_pkg::DEPTH];

  for (genvar i = 0; i < rdq_pkg::DEPTH; i++) begin : g_cell
    logic [rdq_pkg::VALUE_W-1:0] l_data;
    logic                        l_valid;
    logic                        l_seen;
    logic [rdq_pkg::VALUE_W-1:0] r_data;
    logic                        r_valid;

    if (i == 0) begin : g_first
      assign l_data  = cmd.value;
      assign l_valid = 1'b1;
      assign l_seen  = 1'b0;
    end else begin : g_mid
      assign l_data  = data[i-1];
      assign l_valid = valid[i-1];
      assign l_seen  = seen[i-1];
    end

    if (i == rdq_pkg::DEPTH - 1) begin : g_last
      assign r_data  = data[i];
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = data[i+1];
      assign r_valid = valid[i+1];
    end

    rdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .left_seen   (l_seen),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (data[i]),
      .valid       (valid[i]),
      .seen        (seen[i])
    );
  end

  assign stat.front_value = data[0];
  assign stat.found       = seen[rdq_pkg::DEPTH-1];

endmodule
`default_nettype wire

/* design/ring_deque_with_remove.sv */
// top level: fixed-depth deque of 32-bit handles with remove by value
//
// Requests arrive on req (operation, item_value) and every request gives one
// response on rsp (popped_value, status, entry_count, is_empty). Both channels
// transfer when valid and ready are high at a rising clock edge.
// Operations: push back, push front, pop front, remove first match.
// Each request is handled by a compare pass and then a shift pass: in the transfer
// cycle every cell compares its entry with item_value; in the next cycle the row
// of cells shifts or loads in one step and the response register is written.
// The response is visible the cycle after that, and a new request is not taken
// until the compare-then-shift pass over the cells is done.
// req.ready is low while a request is in work and while an unaccepted
// response is held; a stalled receiver therefore holds the block, and the
// response stays stable until it is taken.
// Synchronous reset empties the deque and drops any pending response; the
// block takes a request in the first cycle after reset.
`default_nettype none
module ring_deque_with_remove (
  input  wire logic  clk,
  input  wire logic  rst,
  rdq_req_if.sink    req,
  rdq_rsp_if.source  rsp
);

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_EXEC = 1'b1;

  logic                           state;
  logic [rdq_pkg::OP_W-1:0]       op_q;
  logic [rdq_pkg::VALUE_W-1:0]    value_q;
  logic [rdq_pkg::COUNT_W-1:0]    count;
  logic [rdq_pkg::COUNT_W-1:0]    count_next;
  logic [rdq_pkg::STATUS_W-1:0]   status_next;
  logic [rdq_pkg::VALUE_W-1:0]    popped_next;
  logic                           rsp_valid;
  logic                           accept;
  logic                           full;
  logic                           empty;
  rdq_pkg::cell_cmd_t             cmd;
  rdq_pkg::chain_stat_t           stat;

  assign req.ready = (state == STATE_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == rdq_pkg::COUNT_W'(rdq_pkg::DEPTH));
  assign empty     = (count == '0);
  assign rsp.valid = rsp_valid;

  always_comb begin
    cmd.code    = rdq_pkg::CMD_HOLD;
    cmd.capture = accept;
    cmd.value   = accept ? req.item_value : value_q;
    count_next  = count;
    status_next = rdq_pkg::STAT_OK;
    popped_next = '0;
    if (state == STATE_EXEC) begin
      case (op_q)
        rdq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_next = rdq_pkg::STAT_FULL;
          end else begin
            cmd.code   = rdq_pkg::CMD_PUSH_BACK;
            count_next = count + 1'b1;
          end
        end
        rdq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_next = rdq_pkg::STAT_FULL;
          end else begin
            cmd.code   = rdq_pkg::CMD_PUSH_FRONT;
            count_next = count + 1'b1;
          end
        end
        rdq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_next = rdq_pkg::STAT_EMPTY;
          end else begin
            cmd.code    = rdq_pkg::CMD_POP;
            popped_next = stat.front_value;
            count_next  = count - 1'b1;
          end
        end
        default: begin
          cmd.code = rdq_pkg::CMD_REMOVE;
          if (stat.found) begin
            count_next = count - 1'b1;
          end else begin
            status_next = rdq_pkg::STAT_NOT_FOUND;
          end
        end
      endcase
    end
  end

  rdq_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        STATE_IDLE: begin
          if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
          if (accept) state <= STATE_EXEC;
        end
        STATE_EXEC: begin
          count     <= count_next;
          rsp_valid <= 1'b1;
          state     <= STATE_IDLE;
        end
        default: state <= STATE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.operation;
      value_q <= req.item_value;
    end
    if (state == STATE_EXEC) begin
      rsp.popped_value <= popped_next;
      rsp.status       <= status_next;
      rsp.entry_count  <= count_next;
      rsp.is_empty     <= (count_next == '0);
    end
  end

endmodule
`default_nettype wire
